>>> hdl/slc_pkg.sv
// Shared types, sizes and codes for the set-associative LRU tag cache.
// No dependencies; used by every other file of the block.
package slc_pkg;

  function automatic int floor_log2(input int v);
    int r;
    int x;
    r = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      r = r + 1;
    end
    return r;
  endfunction

  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 64;

  localparam int ADDR_W     = 64;
  localparam int LAT_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // non-power-of-two sizes round down
  localparam int LINE_SHIFT = floor_log2(LINE_BYTES);
  localparam int SET_BITS   = floor_log2(SETS);
  localparam int SETS_USED  = 1 << SET_BITS;
  localparam int SET_IW     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W      = ADDR_W - LINE_SHIFT - SET_BITS;
  localparam int WAY_IW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int REC_W      = WAY_IW;
  localparam int CNT_W      = $clog2(WAYS + 1);

  localparam logic [LAT_W-1:0] HIT_LAT_RST  = LAT_W'(2);
  localparam logic [LAT_W-1:0] MISS_LAT_RST = LAT_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CACHE_ENABLE = 2'd0,
    REG_HIT_LATENCY  = 2'd1,
    REG_MISS_LATENCY = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_TOUCH  = 1'b1
  } req_cmd_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [WAYS-1:0][REC_W-1:0] rec_row_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // take the request, read the set
    logic update;   // write back the set, load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } dp_status_t;

endpackage

>>> hdl/slc_if.sv
// Request and result channel interfaces of the tag cache.
// Depends on slc_pkg for field widths.
interface slc_req_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [slc_pkg::ADDR_W-1:0] address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink (input valid, input cmd, input address, output ready);
endinterface

interface slc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [slc_pkg::LAT_W-1:0] latency;

  modport source (output valid, output hit, output latency, input ready);
  modport sink (input valid, input hit, input latency, output ready);
endinterface

>>> hdl/slc_ctrl.sv
// Sequencing state machine of the tag cache: one request in flight.
// Depends on slc_pkg for the state and command/status types.
module slc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slc_pkg::dp_status_t sts,
  output slc_pkg::ctrl_cmd_t  cmd
);

  slc_pkg::state_t state;
  slc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      slc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = slc_pkg::ST_LOOKUP;
        end
      end
      slc_pkg::ST_LOOKUP: begin
        // hold until the result register can take the new result
        if (!sts.out_stall) begin
          cmd.update = 1'b1;
          state_next = slc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/slc_dp.sv
// Datapath of the tag cache: config registers, tag/recency memories,
// valid flops, compare and LRU update, result register. Depends on slc_pkg.
module slc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_cmd,
  input  logic [slc_pkg::ADDR_W-1:0]       in_address,
  input  slc_pkg::ctrl_cmd_t               cmd,
  output slc_pkg::dp_status_t              sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [slc_pkg::LAT_W-1:0]        out_latency
);

  // configuration
  logic                      cache_enable;
  logic [slc_pkg::LAT_W-1:0] hit_latency;
  logic [slc_pkg::LAT_W-1:0] miss_latency;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enable <= 1'b1;
      hit_latency  <= slc_pkg::HIT_LAT_RST;
      miss_latency <= slc_pkg::MISS_LAT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        slc_pkg::REG_CACHE_ENABLE: cache_enable <= cfg_wdata[0];
        slc_pkg::REG_HIT_LATENCY:  hit_latency  <= cfg_wdata[slc_pkg::LAT_W-1:0];
        slc_pkg::REG_MISS_LATENCY: miss_latency <= cfg_wdata[slc_pkg::LAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request fields
  logic [slc_pkg::SET_IW-1:0] in_set;
  logic                       req_touch;
  logic [slc_pkg::TAG_W-1:0]  req_tag;
  logic [slc_pkg::SET_IW-1:0] req_set;

  assign in_set = (slc_pkg::SET_BITS == 0) ? '0
                : in_address[slc_pkg::LINE_SHIFT +: slc_pkg::SET_IW];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_touch <= (in_cmd == slc_pkg::CMD_TOUCH);
      req_tag   <= in_address[slc_pkg::ADDR_W-1 -: slc_pkg::TAG_W];
      req_set   <= in_set;
    end
  end

  // set storage: one row per set, all ways side by side
  slc_pkg::tag_row_t tag_mem [slc_pkg::SETS_USED];
  slc_pkg::rec_row_t rec_mem [slc_pkg::SETS_USED];
  logic [slc_pkg::SETS_USED-1:0][slc_pkg::WAYS-1:0] valid_bits;

  slc_pkg::tag_row_t               tag_row;
  slc_pkg::rec_row_t               rec_row;
  logic [slc_pkg::WAYS-1:0]        vld_row;
  slc_pkg::tag_row_t               tag_row_next;
  slc_pkg::rec_row_t               rec_row_next;
  logic [slc_pkg::WAYS-1:0]        vld_row_next;
  logic                            write_en;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_row <= tag_mem[in_set];
      rec_row <= rec_mem[in_set];
    end
    if (write_en) begin
      tag_mem[req_set] <= tag_row_next;
      rec_mem[req_set] <= rec_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (write_en) begin
      valid_bits[req_set] <= vld_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vld_row <= valid_bits[in_set];
    end
  end

  // lookup and replacement choice
  logic                          found;
  logic [slc_pkg::WAY_IW-1:0]    hit_way;
  logic                          have_free;
  logic [slc_pkg::WAY_IW-1:0]    free_way;
  logic [slc_pkg::CNT_W-1:0]     valid_count;
  logic [slc_pkg::WAY_IW-1:0]    victim;
  logic [slc_pkg::REC_W-1:0]     victim_rank;
  logic [slc_pkg::WAY_IW-1:0]    sel_way;
  logic [slc_pkg::CNT_W-1:0]     old_rank;

  always_comb begin
    found       = 1'b0;
    hit_way     = '0;
    have_free   = 1'b0;
    free_way    = '0;
    valid_count = '0;
    for (int w = 0; w < slc_pkg::WAYS; w++) begin
      if (vld_row[w]) begin
        valid_count = valid_count + 1'b1;
        if (!found && tag_row[w] == req_tag) begin
          found   = 1'b1;
          hit_way = slc_pkg::WAY_IW'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_way  = slc_pkg::WAY_IW'(w);
      end
    end
  end

  // oldest way; ties go to the lowest index
  always_comb begin
    victim      = '0;
    victim_rank = rec_row[0];
    for (int w = 1; w < slc_pkg::WAYS; w++) begin
      if (rec_row[w] > victim_rank) begin
        victim      = slc_pkg::WAY_IW'(w);
        victim_rank = rec_row[w];
      end
    end
  end

  always_comb begin
    if (found) begin
      sel_way  = hit_way;
      old_rank = slc_pkg::CNT_W'(rec_row[hit_way]);
    end else if (have_free) begin
      sel_way  = free_way;
      old_rank = valid_count;
    end else begin
      sel_way  = victim;
      old_rank = slc_pkg::CNT_W'(victim_rank);
    end
  end

  always_comb begin
    tag_row_next = tag_row;
    rec_row_next = rec_row;
    vld_row_next = vld_row;
    for (int w = 0; w < slc_pkg::WAYS; w++) begin
      if (slc_pkg::WAY_IW'(w) == sel_way) begin
        tag_row_next[w] = req_tag;
        rec_row_next[w] = '0;
        vld_row_next[w] = 1'b1;
      end else if (vld_row[w] && (slc_pkg::CNT_W'(rec_row[w]) < old_rank)) begin
        rec_row_next[w] = slc_pkg::REC_W'(rec_row[w] + 1'b1);
      end
    end
  end

  // disabled cache leaves the state alone
  assign write_en = cmd.update && cache_enable;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit <= cache_enable && found;
      if (req_touch) begin
        out_latency <= '0;
      end else if (cache_enable && found) begin
        out_latency <= hit_latency;
      end else begin
        out_latency <= miss_latency;
      end
    end
  end

  assign sts.out_stall = out_valid && !out_ready;

endmodule

>>> hdl/set_assoc_lru_tag_cache.sv
// Set-associative tag cache with true LRU replacement, top level.
// Requests enter on req (cmd 0 lookup, 1 touch, byte address); one result
// (hit, latency) per request leaves on rsp. Both are valid/ready channels.
// Config: cfg_wr_en writes cfg_wdata to register cfg_index (0 enable,
// 1 hit latency, 2 miss latency); other indexes are ignored. Write config
// only while no request is outstanding.
// One request is handled at a time: on acceptance the set's tag and
// recency rows are read into registers; in the lookup state they are
// compared, updated and written back through the single memory port,
// and the result register is loaded.
// The next request is accepted while the previous result waits in the
// output register. If rsp stalls with a result pending, the next request
// holds in its compare cycle until the result register is taken.
// Reset (synchronous, rst high) clears all valid flops at once and
// restores enable=1 and the slc_pkg reset hit and miss latencies; no clearing pass.
// Depends on slc_pkg, slc_if, slc_ctrl and slc_dp.
module set_assoc_lru_tag_cache (
  input  logic                          clk,
  input  logic                          rst,
  slc_req_if.sink                       req,
  slc_rsp_if.source                     rsp,
  input  logic                          cfg_wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slc_pkg::CFG_W-1:0]     cfg_wdata
);

  slc_pkg::ctrl_cmd_t  cmd;
  slc_pkg::dp_status_t sts;

  slc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_cmd      (req.cmd),
    .in_address  (req.address),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_hit     (rsp.hit),
    .out_latency (rsp.latency)
  );

  // one request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  // a finished lookup always shows up on the result channel
  a_update_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> rsp.valid)
    else $error("result not presented after update");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> !(rsp.valid && !rsp.ready))
    else $error("pending result overwritten");

  // capture and update never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.update))
    else $error("capture and update in the same cycle");

endmodule
